@@ rtl/madd3_pkg.sv @@
// shared types, opcodes and microcode rom for the 3x3 adjugate and determinant unit
package madd3_pkg;

    localparam int ADJ_W  = 33;
    localparam int DET_W  = 49;
    localparam int IDX_W  = 2;
    localparam int PC_W   = 6;
    localparam int FLD_W  = 4;

    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_CLR  = 3'd1;
    localparam logic [2:0] OP_MUL1 = 3'd2;
    localparam logic [2:0] OP_MUL2 = 3'd3;
    localparam logic [2:0] OP_COF  = 3'd4;
    localparam logic [2:0] OP_DMAC = 3'd5;
    localparam logic [2:0] OP_DACC = 3'd6;
    localparam logic [2:0] OP_EMIT = 3'd7;

    localparam logic [1:0] J_NEXT   = 2'd0;
    localparam logic [1:0] J_NOTLD  = 2'd1;
    localparam logic [1:0] J_BUSY   = 2'd2;
    localparam logic [1:0] J_ALWAYS = 2'd3;

    localparam logic [PC_W-1:0] PC_IDLE = 6'd0;
    localparam logic [PC_W-1:0] PC_CLR  = 6'd1;
    localparam logic [PC_W-1:0] PC_DACC = 6'd32;
    localparam logic [PC_W-1:0] PC_EMIT = 6'd33;
    localparam logic [PC_W-1:0] PC_END  = 6'd42;

    typedef struct packed {
        logic [2:0]       op;
        logic [FLD_W-1:0] rda;
        logic [FLD_W-1:0] rdb;
        logic [FLD_W-1:0] idx;
        logic             neg;
        logic [1:0]       cond;
        logic [PC_W-1:0]  tgt;
    } ucode_t;

    function automatic ucode_t uw(input logic [2:0] op, input logic [FLD_W-1:0] rda,
                                  input logic [FLD_W-1:0] rdb, input logic [FLD_W-1:0] idx,
                                  input logic neg, input logic [1:0] cond,
                                  input logic [PC_W-1:0] tgt);
        ucode_t w;
        w.op   = op;
        w.rda  = rda;
        w.rdb  = rdb;
        w.idx  = idx;
        w.neg  = neg;
        w.cond = cond;
        w.tgt  = tgt;
        return w;
    endfunction

    // per cofactor: read first pair, read second pair, two products, difference
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            6'd0:  w = uw(OP_NOP,  4'd0, 4'd0, 4'd0, 1'b0, J_NOTLD,  PC_IDLE);
            6'd1:  w = uw(OP_CLR,  4'd4, 4'd8, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd2:  w = uw(OP_MUL1, 4'd5, 4'd7, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd3:  w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd4:  w = uw(OP_COF,  4'd1, 4'd8, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd5:  w = uw(OP_MUL1, 4'd2, 4'd7, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd6:  w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd7:  w = uw(OP_COF,  4'd1, 4'd5, 4'd1, 1'b1, J_NEXT,   PC_IDLE);
            6'd8:  w = uw(OP_MUL1, 4'd2, 4'd4, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd9:  w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd10: w = uw(OP_COF,  4'd3, 4'd8, 4'd2, 1'b0, J_NEXT,   PC_IDLE);
            6'd11: w = uw(OP_MUL1, 4'd5, 4'd6, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd12: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd13: w = uw(OP_COF,  4'd0, 4'd8, 4'd3, 1'b1, J_NEXT,   PC_IDLE);
            6'd14: w = uw(OP_MUL1, 4'd2, 4'd6, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd15: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd16: w = uw(OP_COF,  4'd0, 4'd5, 4'd4, 1'b0, J_NEXT,   PC_IDLE);
            6'd17: w = uw(OP_MUL1, 4'd2, 4'd3, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd18: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd19: w = uw(OP_COF,  4'd3, 4'd7, 4'd5, 1'b1, J_NEXT,   PC_IDLE);
            6'd20: w = uw(OP_MUL1, 4'd4, 4'd6, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd21: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd22: w = uw(OP_COF,  4'd0, 4'd7, 4'd6, 1'b0, J_NEXT,   PC_IDLE);
            6'd23: w = uw(OP_MUL1, 4'd1, 4'd6, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd24: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd25: w = uw(OP_COF,  4'd0, 4'd4, 4'd7, 1'b1, J_NEXT,   PC_IDLE);
            6'd26: w = uw(OP_MUL1, 4'd1, 4'd3, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd27: w = uw(OP_MUL2, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd28: w = uw(OP_COF,  4'd0, 4'd0, 4'd8, 1'b0, J_NEXT,   PC_IDLE);
            // determinant along the first row
            6'd29: w = uw(OP_DMAC, 4'd1, 4'd1, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd30: w = uw(OP_DMAC, 4'd2, 4'd2, 4'd3, 1'b0, J_NEXT,   PC_IDLE);
            6'd31: w = uw(OP_DMAC, 4'd0, 4'd0, 4'd6, 1'b0, J_NEXT,   PC_IDLE);
            6'd32: w = uw(OP_DACC, 4'd0, 4'd0, 4'd0, 1'b0, J_NEXT,   PC_IDLE);
            6'd33: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd0, 1'b0, J_BUSY,   6'd33);
            6'd34: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd1, 1'b0, J_BUSY,   6'd34);
            6'd35: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd2, 1'b0, J_BUSY,   6'd35);
            6'd36: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd3, 1'b0, J_BUSY,   6'd36);
            6'd37: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd4, 1'b0, J_BUSY,   6'd37);
            6'd38: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd5, 1'b0, J_BUSY,   6'd38);
            6'd39: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd6, 1'b0, J_BUSY,   6'd39);
            6'd40: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd7, 1'b0, J_BUSY,   6'd40);
            6'd41: w = uw(OP_EMIT, 4'd0, 4'd0, 4'd8, 1'b0, J_BUSY,   6'd41);
            default: w = uw(OP_NOP, 4'd0, 4'd0, 4'd0, 1'b0, J_ALWAYS, PC_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] idx_row(input logic [FLD_W-1:0] idx);
        logic [IDX_W-1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_col(input logic [FLD_W-1:0] idx);
        logic [IDX_W-1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/madd3_ram.sv @@
// generic ram, one write port and two registered read ports
module madd3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/matrix_adjugate_determinant_3x3_top.sv @@
// top level: 3x3 adjugate and determinant unit with microcoded sequencer
//
//  channel | ports                                        | transaction
//  s_      | s_valid s_ready s_element_value              | one element, row-major
//  m_      | m_valid m_ready m_adjugate_entry m_entry_row | one adjugate entry with
//          | m_entry_col m_matrix_det m_last_entry        | determinant, last on ninth
//
//  elements load one per cycle while s_ready is high; s_ready is high only while the sequencer sits at step 0
//  after the ninth element the microprogram does its cofactor and determinant work on one
//  shared 2-port element ram, then 9 emit steps, then one return step
//  each emit step waits on a stall
//  synchronous active-low reset returns the sequencer to step 0 with no pending output
module matrix_adjugate_determinant_3x3_top #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int MATRIX_SIZE   = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [15:0]                    s_element_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [madd3_pkg::ADJ_W-1:0]    m_adjugate_entry,
    output logic        [madd3_pkg::IDX_W-1:0]    m_entry_row,
    output logic        [madd3_pkg::IDX_W-1:0]    m_entry_col,
    output logic signed [madd3_pkg::DET_W-1:0]    m_matrix_det,
    output logic                                  m_last_entry
);

    import madd3_pkg::*;

    localparam int CELLS   = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW      = $clog2(CELLS);
    localparam int PROD_W  = 2 * ELEMENT_WIDTH;
    localparam int COF_W   = PROD_W + 1;
    localparam int DPROD_W = ELEMENT_WIDTH + ADJ_W;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [AW-1:0]   load_count_reg, load_count_next;
    ucode_t          uc;
    logic            in_acc, last_load, out_busy, emit_fire, take_jump;

    logic [ELEMENT_WIDTH-1:0]        ram_a, ram_b;
    logic signed [ELEMENT_WIDTH-1:0] ram_as, ram_bs;

    logic signed [PROD_W-1:0]  p_reg, q_reg, mprod;
    logic signed [COF_W-1:0]   cof_diff;
    logic signed [ADJ_W-1:0]   cof_ext, cof_val, cof_sel;
    logic signed [ADJ_W-1:0]   cof_reg [CELLS];
    logic signed [DPROD_W-1:0] dprod_reg, dprod;
    logic signed [DET_W-1:0]   det_reg;

    logic                    m_valid_reg, m_valid_next;
    logic signed [ADJ_W-1:0] m_adj_reg;
    logic [IDX_W-1:0]        m_row_reg, m_col_reg;
    logic signed [DET_W-1:0] m_det_reg;
    logic                    m_last_reg;

    // sequencer
    assign uc        = ucode_rom(pc_reg);
    assign s_ready   = (pc_reg == PC_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign last_load = in_acc && (load_count_reg == AW'(CELLS - 1));
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit_fire = (uc.op == OP_EMIT) && !out_busy;

    always_comb begin
        case (uc.cond)
            J_NOTLD:  take_jump = !last_load;
            J_BUSY:   take_jump = out_busy;
            J_ALWAYS: take_jump = 1'b1;
            default:  take_jump = 1'b0;
        endcase
        pc_next = take_jump ? uc.tgt : pc_reg + PC_W'(1);
    end

    always_comb begin
        load_count_next = load_count_reg;
        if (in_acc) begin
            load_count_next = last_load ? '0 : load_count_reg + AW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= PC_IDLE;
            load_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            load_count_reg <= load_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // element store
    madd3_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CELLS)
    ) u_store (
        .aclk    (aclk),
        .we      (in_acc),
        .waddr   (load_count_reg),
        .wdata   (s_element_value[ELEMENT_WIDTH-1:0]),
        .raddr_a (AW'(uc.rda)),
        .raddr_b (AW'(uc.rdb)),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // datapath
    assign ram_as   = $signed(ram_a);
    assign ram_bs   = $signed(ram_b);
    assign mprod    = ram_as * ram_bs;
    assign cof_diff = COF_W'(p_reg) - COF_W'(q_reg);
    assign cof_ext  = ADJ_W'(cof_diff);
    assign cof_val  = uc.neg ? -cof_ext : cof_ext;
    assign cof_sel  = cof_reg[AW'(uc.idx)];
    assign dprod    = ram_as * cof_sel;

    always_ff @(posedge aclk) begin
        case (uc.op)
            OP_CLR: begin
                dprod_reg <= '0;
                det_reg   <= '0;
            end
            OP_MUL1: begin
                p_reg <= mprod;
            end
            OP_MUL2: begin
                q_reg <= mprod;
            end
            OP_COF: begin
                cof_reg[AW'(uc.idx)] <= cof_val;
            end
            OP_DMAC: begin
                dprod_reg <= dprod;
                det_reg   <= det_reg + DET_W'(dprod_reg);
            end
            OP_DACC: begin
                det_reg <= det_reg + DET_W'(dprod_reg);
            end
            default: begin
            end
        endcase
        if (emit_fire) begin
            m_adj_reg  <= cof_sel;
            m_row_reg  <= idx_row(uc.idx);
            m_col_reg  <= idx_col(uc.idx);
            m_det_reg  <= det_reg;
            m_last_reg <= (pc_reg == PC_END - PC_W'(1));
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_adjugate_entry = m_adj_reg;
    assign m_entry_row      = m_row_reg;
    assign m_entry_col      = m_col_reg;
    assign m_matrix_det     = m_det_reg;
    assign m_last_entry     = m_last_reg;

    // checks
    a_start_after_ninth: assert property (@(posedge aclk) disable iff (!aresetn)
        last_load |=> pc_reg == PC_CLR)
        else $error("sequencer did not start after ninth element");

    a_count_idle_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg != PC_IDLE |-> load_count_reg == '0)
        else $error("load count nonzero while sequencer runs");

    a_det_held_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg > PC_DACC |=> $stable(det_reg))
        else $error("determinant changed during emission");

    a_last_is_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_row_reg == 2'd2 && m_col_reg == 2'd2)
        else $error("last entry not at row 2 column 2");

endmodule

@@ bench/tb_top.sv @@
// testbench for the 3x3 adjugate and determinant unit: directed, back-pressure and random matrices
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import madd3_pkg::*;

    typedef struct {
        logic signed [ADJ_W-1:0] adj;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DET_W-1:0] det;
        logic                    last;
    } adj_entry_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_element_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [ADJ_W-1:0]  m_adjugate_entry;
    logic [IDX_W-1:0]         m_entry_row;
    logic [IDX_W-1:0]         m_entry_col;
    logic signed [DET_W-1:0]  m_matrix_det;
    logic                     m_last_entry;

    matrix_adjugate_determinant_3x3_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_adjugate_entry (m_adjugate_entry),
        .m_entry_row      (m_entry_row),
        .m_entry_col      (m_entry_col),
        .m_matrix_det     (m_matrix_det),
        .m_last_entry     (m_last_entry)
    );

    logic signed [15:0] mat_elem [9];
    int unsigned        elems_loaded = 0;
    adj_entry_t         pending_entries [$];
    adj_entry_t         want_entry;
    int unsigned        mismatch_count = 0;
    int unsigned        burst_left = 0;
    int unsigned        hold_asked = 0;
    int unsigned        hold_served = 0;
    int unsigned        rx_hold_left = 0;
    int unsigned        rx_cycle = 0;
    int unsigned        rx_mode = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t ns mismatch: %s", $realtime, what);
        end
    endtask

    // signed cofactor of element (i,j) in cyclic form, sign already included
    function automatic longint cofactor(input int i, input int j);
        int i1;
        int i2;
        int j1;
        int j2;
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        return longint'(mat_elem[i1*3+j1]) * longint'(mat_elem[i2*3+j2])
             - longint'(mat_elem[i1*3+j2]) * longint'(mat_elem[i2*3+j1]);
    endfunction

    task automatic predict_adjugate(input logic signed [15:0] value);
        longint     det;
        longint     cof;
        adj_entry_t e;
        mat_elem[elems_loaded] = value;
        elems_loaded++;
        if (elems_loaded == 9) begin
            elems_loaded = 0;
            det = 0;
            for (int j = 0; j < 3; j++) begin
                det += longint'(mat_elem[j]) * cofactor(0, j);
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    cof    = cofactor(c, r);
                    e.adj  = cof[ADJ_W-1:0];
                    e.row  = IDX_W'(r);
                    e.col  = IDX_W'(c);
                    e.det  = det[DET_W-1:0];
                    e.last = (r == 2 && c == 2);
                    pending_entries.push_back(e);
                end
            end
        end
    endtask

    // one element transaction, sent in bursts with random gaps
    task automatic send_element(input logic signed [15:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 14);
        end
        s_valid         <= 1'b1;
        s_element_value <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_adjugate(value);
        burst_left--;
    endtask

    task automatic send_matrix(input logic signed [15:0] m [9]);
        for (int k = 0; k < 9; k++) begin
            send_element(m[k]);
        end
    endtask

    function automatic logic signed [15:0] rand_element();
        logic signed [15:0] v;
        case ($urandom_range(0, 8))
            0, 1, 2, 3: v = 16'($urandom_range(0, 65535));
            4, 5:       v = 16'(int'($urandom_range(0, 16)) - 8);
            6: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sh0000;
                    default: v = 16'shffff;
                endcase
            end
            7:       v = 16'(32'd1 << $urandom_range(0, 15));
            default: v = ($urandom_range(0, 1) == 1) ? 16'(32767 - $urandom_range(0, 3))
                                                     : 16'(-32768 + int'($urandom_range(0, 3)));
        endcase
        return v;
    endfunction

    // receiver: pattern of its own, plus a long hold-off on request
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served  <= hold_asked;
            rx_hold_left <= 400;
            m_ready      <= 1'b0;
        end else begin
            if (rx_cycle % 48 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction row %0d col %0d",
                                          m_entry_row, m_entry_col));
            end else begin
                want_entry = pending_entries.pop_front();
                if (m_adjugate_entry !== want_entry.adj) begin
                    report_mismatch($sformatf("adjugate (%0d,%0d) got %0d want %0d",
                                              want_entry.row, want_entry.col,
                                              m_adjugate_entry, want_entry.adj));
                end
                if (m_entry_row !== want_entry.row) begin
                    report_mismatch($sformatf("row got %0d want %0d",
                                              m_entry_row, want_entry.row));
                end
                if (m_entry_col !== want_entry.col) begin
                    report_mismatch($sformatf("col got %0d want %0d",
                                              m_entry_col, want_entry.col));
                end
                if (m_matrix_det !== want_entry.det) begin
                    report_mismatch($sformatf("determinant got %0d want %0d",
                                              m_matrix_det, want_entry.det));
                end
                if (m_last_entry !== want_entry.last) begin
                    report_mismatch($sformatf("last got %0b want %0b",
                                              m_last_entry, want_entry.last));
                end
            end
        end
    end

    task automatic test_extreme_matrices();
        logic signed [15:0] m [9];
        m = '{16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh8000};
        send_matrix(m);
        m = '{16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000};
        send_matrix(m);
    endtask

    task automatic test_small_matrix();
        logic signed [15:0] m [9];
        m = '{16'sd2, -16'sd1, 16'sd0,
              -16'sd1, 16'sd2, -16'sd1,
              16'sd0, -16'sd1, 16'sd2};
        send_matrix(m);
    endtask

    // receiver holds off while the sender keeps offering whole matrices
    task automatic test_output_backpressure();
        logic signed [15:0] m [9];
        hold_asked++;
        for (int n = 0; n < 4; n++) begin
            for (int k = 0; k < 9; k++) begin
                m[k] = rand_element();
            end
            send_matrix(m);
        end
    endtask

    task automatic test_random_matrices(input int unsigned n_matrices);
        logic signed [15:0] m [9];
        for (int unsigned n = 0; n < n_matrices; n++) begin
            for (int k = 0; k < 9; k++) begin
                m[k] = rand_element();
            end
            // singular matrix: repeated row
            if ($urandom_range(0, 7) == 0) begin
                for (int k = 0; k < 3; k++) begin
                    m[6+k] = m[k];
                end
            end
            send_matrix(m);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extreme_matrices();
        test_small_matrix();
        test_output_backpressure();
        test_random_matrices(35);
        s_valid <= 1'b0;
        while (pending_entries.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/madd3_pkg.sv
rtl/madd3_ram.sv
rtl/matrix_adjugate_determinant_3x3_top.sv
bench/tb_top.sv
